// File: design/lfsf_pkg.sv
// Package of the largest free square finder.
// Holds bound defaults, field widths, codes and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package lfsf_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] OBSTACLE_RST = 8'd111;
    localparam logic [CHAR_W-1:0] FILL_RST     = 8'd120;

    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL     = 2'd1;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_PAINT = 1'b1;

    localparam logic KIND_PAINT  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] ch;
        logic              eor;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [SIZE_W-1:0] size;
        logic              found;
        logic              overflow;
        logic              last;
    } t_result;

endpackage

// File: design/lfsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module lfsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lfsf_outq.sv
// Two-word output queue of the largest free square finder.
// Depends on lfsf_pkg for the result word type.
`timescale 1ns / 1ps

module lfsf_outq
    import lfsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    output logic       o_valid,
    output t_result    o_data,
    input  logic       i_ready,
    output logic [1:0] o_count
);

    logic    r_v0, r_v1, n_v0, n_v1;
    t_result r_d0, r_d1, n_d0, n_d1;
    logic    pop;

    assign pop = r_v0 & i_ready;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (pop) begin
            n_v0 = r_v1;
            n_d0 = r_d1;
            n_v1 = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = i_data;
            end else begin
                n_v1 = 1'b1;
                n_d1 = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_valid = r_v0;
    assign o_data  = r_d0;
    assign o_count = {r_v0 & r_v1, r_v0 ^ r_v1};

endmodule

// File: design/lfsf_dp.sv
// Two-stage line-buffer datapath: position counters and line read, then
// side update, best square tracking and painting. Depends on lfsf_pkg, lfsf_ram.
`timescale 1ns / 1ps

module lfsf_dp
    import lfsf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_op,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_eor,
    input  logic              i_eom,
    input  logic [CHAR_W-1:0] i_obstacle,
    input  logic [CHAR_W-1:0] i_fill,
    output logic              o_has_result,
    output t_result           o_result
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int AW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int XW = (CW > RW ? CW : RW) + 1;

    // scan and paint position counters
    logic [CW-1:0] r_col, r_prevlen, r_pcol;
    logic [RW-1:0] r_row, r_prow;
    logic          r_overflow;

    // second stage
    logic              r_s1_valid;
    logic              r_s1_op;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_eor, r_s1_eom;
    logic              r_s1_beyond, r_s1_first, r_s1_upok, r_s1_ovf;
    logic [CW-1:0]     r_s1_col;
    logic [RW-1:0]     r_s1_row;
    logic              r_fwd;
    logic [CW-1:0]     r_fwd_val;

    logic [CW-1:0] r_left, r_diag;
    logic [CW-1:0] r_best_size, r_best_col;
    logic [RW-1:0] r_best_row;

    logic          scan_beyond, paint_beyond, fwd_hit;
    logic [CW-1:0] row_len;
    logic [CW-1:0] ram_rdata, up, left, diag, m0, m1, v;
    logic          s1_scan_wr;
    logic [CW-1:0] base_size, n_best_size, n_best_col;
    logic [RW-1:0] base_row, n_best_row;
    logic          in_square;

    assign scan_beyond  = (r_col >= CW'(MAX_COLS)) || (r_row >= RW'(MAX_ROWS));
    assign paint_beyond = (r_pcol >= CW'(MAX_COLS)) || (r_prow >= RW'(MAX_ROWS));
    assign row_len      = (r_col < CW'(MAX_COLS)) ? r_col + CW'(1) : CW'(MAX_COLS);
    assign s1_scan_wr   = r_s1_valid && (r_s1_op == OP_SCAN) && !r_s1_beyond;
    assign fwd_hit      = s1_scan_wr && (r_s1_col == r_col);

    lfsf_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_scan_wr),
        .i_waddr (r_s1_col[AW-1:0]),
        .i_wdata (v),
        .i_raddr (r_col[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // side value of the current cell
    always_comb begin
        up   = !r_s1_upok ? '0 : (r_fwd ? r_fwd_val : ram_rdata);
        left = (r_s1_col == '0) ? '0 : r_left;
        diag = (r_s1_col == '0) ? '0 : r_diag;
        m0   = (up < left) ? up : left;
        m1   = (m0 < diag) ? m0 : diag;
        v    = (r_s1_char == i_obstacle) ? '0 : m1 + CW'(1);
    end

    always_comb begin
        base_size   = r_s1_first ? '0 : r_best_size;
        base_row    = r_s1_first ? '0 : r_best_row;
        n_best_size = base_size;
        n_best_row  = base_row;
        n_best_col  = r_s1_first ? '0 : r_best_col;
        if (!r_s1_beyond && (v > base_size)) begin
            n_best_size = v;
            n_best_row  = RW'(r_s1_row + RW'(1) - RW'(v));
            n_best_col  = r_s1_col + CW'(1) - v;
        end
    end

    assign in_square = (r_best_size != '0) && !r_s1_beyond &&
                       (r_s1_row >= r_best_row) &&
                       (XW'(r_s1_row - r_best_row) < XW'(r_best_size)) &&
                       (r_s1_col >= r_best_col) &&
                       (XW'(r_s1_col - r_best_col) < XW'(r_best_size));

    always_comb begin
        o_result = '0;
        if (r_s1_op == OP_SCAN) begin
            o_result.kind     = KIND_REPORT;
            o_result.row      = POS_W'(n_best_row);
            o_result.col      = POS_W'(n_best_col);
            o_result.size     = SIZE_W'(n_best_size);
            o_result.found    = (n_best_size != '0);
            o_result.overflow = r_s1_ovf;
            o_result.last     = 1'b1;
        end else begin
            o_result.kind     = KIND_PAINT;
            o_result.ch       = in_square ? i_fill : r_s1_char;
            o_result.eor      = r_s1_eor;
            o_result.overflow = r_s1_beyond;
            o_result.last     = r_s1_eom;
        end
    end

    assign o_has_result = r_s1_valid && ((r_s1_op == OP_PAINT) || r_s1_eom);

    // first stage: counters and line read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_prevlen  <= '0;
            r_pcol     <= '0;
            r_prow     <= '0;
            r_overflow <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (i_accept && (i_op == OP_SCAN)) begin
                if (i_eom) begin
                    r_col      <= '0;
                    r_row      <= '0;
                    r_prevlen  <= '0;
                    r_overflow <= 1'b0;
                    r_pcol     <= '0;
                    r_prow     <= '0;
                end else begin
                    if (scan_beyond) begin
                        r_overflow <= 1'b1;
                    end
                    if (i_eor) begin
                        r_col <= '0;
                        if (r_row < RW'(MAX_ROWS)) begin
                            r_prevlen <= row_len;
                            r_row     <= r_row + RW'(1);
                        end
                    end else if (r_col < CW'(MAX_COLS)) begin
                        r_col <= r_col + CW'(1);
                    end
                end
            end else if (i_accept) begin
                if (i_eom) begin
                    r_pcol <= '0;
                    r_prow <= '0;
                end else if (i_eor) begin
                    r_pcol <= '0;
                    if (r_prow < RW'(MAX_ROWS)) begin
                        r_prow <= r_prow + RW'(1);
                    end
                end else if (r_pcol < CW'(MAX_COLS)) begin
                    r_pcol <= r_pcol + CW'(1);
                end
            end
        end
        r_s1_op   <= i_op;
        r_s1_char <= i_char;
        r_s1_eor  <= i_eor;
        r_s1_eom  <= i_eom;
        r_fwd     <= fwd_hit;
        r_fwd_val <= v;
        if (i_op == OP_SCAN) begin
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_beyond <= scan_beyond;
        end else begin
            r_s1_col    <= r_pcol;
            r_s1_row    <= r_prow;
            r_s1_beyond <= paint_beyond;
        end
        r_s1_first <= (r_col == '0) && (r_row == '0);
        r_s1_upok  <= (r_col < r_prevlen);
        r_s1_ovf   <= r_overflow | scan_beyond;
    end

    // second stage: side values and best square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (r_s1_valid && (r_s1_op == OP_SCAN)) begin
            r_best_size <= n_best_size;
            r_best_row  <= n_best_row;
            r_best_col  <= n_best_col;
            if (!r_s1_beyond) begin
                r_left <= v;
                r_diag <= up;
            end
        end
    end

endmodule

// File: design/largest_free_square_finder.sv
// Top level of the largest free square finder.
// Depends on lfsf_pkg, lfsf_dp, lfsf_outq (and lfsf_ram below lfsf_dp).
//
// Usage: stream a map cell by cell in row-major order on s_axis with
// tuser = 0 (scan). tlast marks the last cell of the map, tdata[8] the last
// cell of a row. At end of map one report word comes out on m_axis with
// tuser = 1 holding the top-left row, column and side of the largest square
// free of the obstacle character (first in row-major order on ties), found and
// overflow. Then stream the map again with tuser = 1 (paint): every cell comes
// back, cells inside the square replaced by the fill character.
// Config writes (index 0 obstacle, 1 fill) take effect at once; write only
// while no words are in flight.
// Throughput: one cell per cycle while s_axis_tready is high. Each cell is a
// single read-modify-write of the line memory, read in the accept cycle and
// written in the next. Result words leave the second-stage registers through a
// two-word output queue that decouples the sides; when the receiver stalls the
// queue fills and s_axis_tready drops, no word is lost.
// Reset clears counters, best square and queue; the line memory needs no clear.
`timescale 1ns / 1ps

module largest_free_square_finder
    import lfsf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // cell_char, end_of_row, zero pad
    input  logic                 s_axis_tuser,   // operation
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // out_char, out_end_of_row, square_row,
                                                 // square_col, square_size, found,
                                                 // overflow, zero pad
    output logic                 m_axis_tuser,   // result_kind
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [CHAR_W-1:0] r_obstacle, r_fill;
    logic              accept, has_result, pop;
    logic [1:0]        q_count;
    logic [2:0]        in_flight;
    t_result           s1_result, q_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle <= OBSTACLE_RST;
            r_fill     <= FILL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OBSTACLE: r_obstacle <= i_cfg_data;
                CFG_FILL:     r_fill     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pop           = m_axis_tvalid & m_axis_tready;
    assign in_flight     = 3'(q_count) + 3'(has_result) - 3'(pop);
    assign s_axis_tready = (in_flight <= 3'd1);
    assign accept        = s_axis_tvalid & s_axis_tready;

    lfsf_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (s_axis_tuser),
        .i_char       (s_axis_tdata[7:0]),
        .i_eor        (s_axis_tdata[8]),
        .i_eom        (s_axis_tlast),
        .i_obstacle   (r_obstacle),
        .i_fill       (r_fill),
        .o_has_result (has_result),
        .o_result     (s1_result)
    );

    lfsf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (has_result),
        .i_data  (s1_result),
        .o_valid (m_axis_tvalid),
        .o_data  (q_result),
        .i_ready (m_axis_tready),
        .o_count (q_count)
    );

    assign m_axis_tdata = {6'b0, q_result.overflow, q_result.found, q_result.size,
                           q_result.col, q_result.row, q_result.eor, q_result.ch};
    assign m_axis_tuser = q_result.kind;
    assign m_axis_tlast = q_result.last;

endmodule

// File: bench/largest_free_square_finder_test.sv
// Self-checking bench for largest_free_square_finder: scan and paint passes over
// directed, random and ragged maps, checked against a square tracker.
// Depends on lfsf_pkg and the largest_free_square_finder RTL.
`timescale 1ns / 1ps

module largest_free_square_finder_test;
    import lfsf_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 825;
    localparam int QUIET_TAIL    = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_SHOWN     = 10;

    localparam logic [10:0] COL_BOUND = 11'(MAX_COLS_DEF);
    localparam logic [10:0] ROW_BOUND = 11'(MAX_ROWS_DEF);

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    localparam logic [CHAR_W-1:0] FREE = 8'h2E;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic              eor;
        logic              eom;
    } map_cell_t;

    typedef struct packed {
        map_cell_t item;
        logic      typed;
        t_result   want;
    } step_row_t;

    localparam t_result NO_WORD = '0;
    localparam int N_DIRECTED = 25;

    // typed rows: after reset, defaults of both registers, all-blocked and single-cell maps
    step_row_t directed [N_DIRECTED] = '{
        '{'{OP_PAINT, 8'h00, 1'b0, 1'b0}, 1'b1,
          '{KIND_PAINT, 8'h00, 1'b0, 10'd0, 10'd0, 11'd0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_PAINT, 8'hFF, 1'b1, 1'b1}, 1'b1,
          '{KIND_PAINT, 8'hFF, 1'b1, 10'd0, 10'd0, 11'd0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_SCAN, OBSTACLE_RST, 1'b1, 1'b1}, 1'b1,
          '{KIND_REPORT, 8'h00, 1'b0, 10'd0, 10'd0, 11'd0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_SCAN, 8'h00, 1'b0, 1'b1}, 1'b1,
          '{KIND_REPORT, 8'h00, 1'b0, 10'd0, 10'd0, 11'd1, 1'b1, 1'b0, 1'b1}},
        '{'{OP_PAINT, 8'h41, 1'b1, 1'b1}, 1'b1,
          '{KIND_PAINT, FILL_RST, 1'b1, 10'd0, 10'd0, 11'd0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_SCAN, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, OBSTACLE_RST, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, FREE, 1'b1, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, FREE, 1'b1, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, 8'hFF, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, 8'h80, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_SCAN, FREE, 1'b0, 1'b1}, 1'b0, NO_WORD},
        '{'{OP_PAINT, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, OBSTACLE_RST, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, FREE, 1'b1, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, FREE, 1'b1, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, 8'hFF, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, 8'h80, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, FREE, 1'b0, 1'b0}, 1'b0, NO_WORD},
        '{'{OP_PAINT, FREE, 1'b0, 1'b1}, 1'b0, NO_WORD}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    largest_free_square_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // square tracker state
    logic [CHAR_W-1:0] obst_q = OBSTACLE_RST;
    logic [CHAR_W-1:0] fill_q = FILL_RST;
    logic [10:0]       side_line [MAX_COLS_DEF];
    logic [10:0]       left_side = '0;
    logic [10:0]       diag_side = '0;
    logic [10:0]       col_n = '0;
    logic [10:0]       row_n = '0;
    logic [10:0]       prev_len = '0;
    logic [10:0]       best_side = '0;
    logic [POS_W-1:0]  best_r = '0;
    logic [POS_W-1:0]  best_c = '0;
    logic [10:0]       paint_r = '0;
    logic [10:0]       paint_c = '0;
    logic              ovf_seen = 1'b0;

    t_result due_words [$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int cycles = 0;
    int n_cells = 0;
    int n_reports = 0;
    int n_painted = 0;
    int n_writes = 0;
    int n_retunes = 0;
    int n_bad = 0;

    function automatic bit step_square_search(input map_cell_t c, output t_result w);
        logic [10:0] up, dg, lf, m, v, len;
        logic        beyond, in_square;
        w = '0;
        if (c.op == OP_SCAN) begin
            if (row_n == '0 && col_n == '0) begin
                best_side = '0;
                best_r = '0;
                best_c = '0;
            end
            if (col_n >= COL_BOUND || row_n >= ROW_BOUND) begin
                ovf_seen = 1'b1;
            end else begin
                up = (col_n < prev_len) ? side_line[col_n[9:0]] : 11'd0;
                dg = (col_n == '0) ? 11'd0 : diag_side;
                lf = (col_n == '0) ? 11'd0 : left_side;
                m = (up < lf) ? up : lf;
                m = (m < dg) ? m : dg;
                v = (c.ch == obst_q) ? 11'd0 : m + 11'd1;
                diag_side = up;
                side_line[col_n[9:0]] = v;
                left_side = v;
                if (v > best_side) begin
                    best_side = v;
                    best_r = 10'(row_n + 11'd1 - v);
                    best_c = 10'(col_n + 11'd1 - v);
                end
            end
            if (c.eor || c.eom) begin
                len = col_n + 11'd1;
                if (row_n < ROW_BOUND) begin
                    prev_len = (len < COL_BOUND) ? len : COL_BOUND;
                    row_n = row_n + 11'd1;
                end
                col_n = '0;
                left_side = '0;
                diag_side = '0;
            end else if (col_n < COL_BOUND) begin
                col_n = col_n + 11'd1;
            end
            if (!c.eom) return 1'b0;
            w.kind = KIND_REPORT;
            w.row = best_r;
            w.col = best_c;
            w.size = best_side;
            w.found = (best_side != '0);
            w.overflow = ovf_seen;
            w.last = 1'b1;
            col_n = '0;
            row_n = '0;
            prev_len = '0;
            left_side = '0;
            diag_side = '0;
            ovf_seen = 1'b0;
            paint_r = '0;
            paint_c = '0;
            return 1'b1;
        end
        beyond = (paint_r >= ROW_BOUND) || (paint_c >= COL_BOUND);
        in_square = (best_side != '0) && !beyond &&
                    paint_r >= 11'(best_r) && (paint_r - 11'(best_r)) < best_side &&
                    paint_c >= 11'(best_c) && (paint_c - 11'(best_c)) < best_side;
        w.kind = KIND_PAINT;
        w.ch = in_square ? fill_q : c.ch;
        w.eor = c.eor;
        w.overflow = beyond;
        w.last = c.eom;
        if (c.eom) begin
            paint_r = '0;
            paint_c = '0;
        end else if (c.eor) begin
            paint_c = '0;
            if (paint_r < ROW_BOUND) paint_r = paint_r + 11'd1;
        end else if (paint_c < COL_BOUND) begin
            paint_c = paint_c + 11'd1;
        end
        return 1'b1;
    endfunction

    function automatic string show_word(input t_result w);
        return $sformatf({"kind=%0d ch=%02h eor=%0d row=%0d col=%0d size=%0d",
                          " found=%0d ovf=%0d last=%0d"},
                         w.kind, w.ch, w.eor, w.row, w.col, w.size, w.found, w.overflow, w.last);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic check_word();
        t_result got, want;
        got.kind = m_axis_tuser;
        got.ch = m_axis_tdata[7:0];
        got.eor = m_axis_tdata[8];
        got.row = m_axis_tdata[18:9];
        got.col = m_axis_tdata[28:19];
        got.size = m_axis_tdata[39:29];
        got.found = m_axis_tdata[40];
        got.overflow = m_axis_tdata[41];
        got.last = m_axis_tlast;
        if (got.kind == KIND_REPORT) n_reports++;
        else n_painted++;
        if (due_words.size() == 0) begin
            n_bad++;
            if (n_bad <= MAX_SHOWN) $display("tb: unexpected word %s", show_word(got));
        end else begin
            want = due_words.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.eor !== want.eor ||
                got.row !== want.row || got.col !== want.col || got.size !== want.size ||
                got.found !== want.found || got.overflow !== want.overflow ||
                got.last !== want.last) begin
                n_bad++;
                if (n_bad <= MAX_SHOWN) begin
                    $display("tb: mismatch at cycle %0d", cycles);
                    $display("tb:   expected %s", show_word(want));
                    $display("tb:   actual   %s", show_word(got));
                end
            end
        end
    endtask

    // receive side: check, then stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_word();
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n && idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_cell(input map_cell_t c, input bit typed = 1'b0,
                             input t_result want = '0);
        t_result w;
        int      gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, c.eor, c.ch};
        s_axis_tuser <= c.op;
        s_axis_tlast <= c.eom;
        do @(posedge i_clk); while (!s_axis_tready);
        n_cells++;
        if (step_square_search(c, w)) due_words.push_back(typed ? want : w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_writes++;
        if (idx == CFG_OBSTACLE) obst_q = val;
        else if (idx == CFG_FILL) fill_q = val;
    endtask

    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic retune_registers();
        logic [7:0] ob, fl;
        case (n_retunes)
            0: begin
                ob = 8'h00;
                fl = 8'hFF;
            end
            1: begin
                ob = 8'hFF;
                fl = 8'h00;
            end
            default: begin
                ob = pick_char();
                fl = pick_char();
            end
        endcase
        n_retunes++;
        drain_stream();
        write_reg(CFG_OBSTACLE, ob);
        write_reg(CFG_FILL, fl);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE2 : CFG_SPARE3, 8'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    // scan a random map, then paint it back unless told not to
    task automatic run_map(input int rows, input int w_lo, input int w_hi,
                           input int block_pct, input bit do_paint);
        map_cell_t cells [$];
        map_cell_t c;
        int        w;
        for (int r = 0; r < rows; r++) begin
            w = $urandom_range(w_lo, w_hi);
            for (int k = 0; k < w; k++) begin
                c.op = OP_SCAN;
                c.ch = ($urandom_range(0, 99) < block_pct) ? obst_q : 8'($urandom());
                c.eom = (r == rows - 1) && (k == w - 1);
                c.eor = (k == w - 1) && !(c.eom && $urandom_range(0, 1) == 0);
                cells.push_back(c);
            end
        end
        foreach (cells[i]) push_cell(cells[i]);
        if (do_paint) begin
            foreach (cells[i]) begin
                c = cells[i];
                c.op = OP_PAINT;
                push_cell(c);
            end
        end
    endtask

    initial begin
        map_cell_t c;
        int        random_start, n_maps, n_noise, w_lo, w_hi, pct;
        n_maps = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // spare indexes must leave both registers alone
        write_reg(CFG_SPARE2, FREE);
        write_reg(CFG_SPARE3, 8'hFF);
        i_cfg_valid <= 1'b0;

        for (int i = 0; i < N_DIRECTED; i++)
            push_cell(directed[i].item, directed[i].typed, directed[i].want);

        retune_registers();
        random_start = n_cells;
        while (n_cells - random_start < RANDOM_ITEMS) begin
            idle_on = (n_maps % 6 != 5) &&
                      (n_cells - random_start < RANDOM_ITEMS - QUIET_TAIL);
            if ($urandom_range(0, 7) == 0) retune_registers();
            pct = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 40);
            w_lo = $urandom_range(1, 10);
            w_hi = $urandom_range(0, 1) ? w_lo : $urandom_range(w_lo, 12);
            if ($urandom_range(0, 4) == 0) begin
                n_noise = $urandom_range(1, 6);
                for (int k = 0; k < n_noise; k++) begin
                    c.op = 1'($urandom_range(0, 1));
                    c.ch = 8'($urandom());
                    c.eor = ($urandom_range(0, 3) == 0);
                    c.eom = ($urandom_range(0, 7) == 0);
                    push_cell(c);
                end
            end else if ($urandom_range(0, 9) == 0) begin
                run_map($urandom_range(8, 16), 8, 16, $urandom_range(0, 20), 1'b1);
            end else begin
                run_map($urandom_range(1, 8), w_lo, w_hi, pct, $urandom_range(0, 9) != 0);
            end
            n_maps++;
        end

        idle_on = 1'b0;
        drain_stream();
        $display("tb: %0d cells sent, %0d reports and %0d painted cells seen, %0d writes",
                 n_cells, n_reports, n_painted, n_writes);
        $display("tb: %0d random maps and noise runs with ragged rows, %0d bad",
                 n_maps, n_bad);
        if (n_bad == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lfsf_pkg.sv
design/lfsf_ram.sv
design/lfsf_outq.sv
design/lfsf_dp.sv
design/largest_free_square_finder.sv
bench/largest_free_square_finder_test.sv
